// ===== src/vau_pkg.sv =====
// vau_pkg: shared types, codes and the saturation helper for the vector
// arithmetic unit. No dependencies.
package vau_pkg;

   localparam logic [2:0] CMD_SUB   = 3'd0;
   localparam logic [2:0] CMD_SCALE = 3'd1;
   localparam logic [2:0] CMD_DOT   = 3'd2;
   localparam logic [2:0] CMD_LEN   = 3'd3;
   localparam logic [2:0] CMD_UNIT  = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
      logic signed [31:0] factor;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic signed [31:0] scalar_result;
      logic [1:0]         status;
   } rsp_type;

   // Per-transaction sideband carried down the pipeline.
   typedef struct packed {
      logic [2:0]       cmd;
      logic [2:0][31:0] a;
      logic [2:0][31:0] r;
      logic [31:0]      sc;
      logic             sat;
   } side_type;

   typedef struct packed {
      logic        sat;
      logic [31:0] value;
   } clamp_type;

   // Saturate to a cw-bit signed range, result sign extended to 32 bits.
   function automatic clamp_type clamp_comp(input logic signed [65:0] v,
                                            input int unsigned cw);
      logic signed [65:0] hi;
      logic signed [65:0] lo;
      clamp_type          c;
      hi = (66'sd1 <<< (cw - 1)) - 66'sd1;
      lo = -hi - 66'sd1;
      c.sat = 1'b0;
      c.value = v[31:0];
      if (v > hi) begin
         c.sat = 1'b1;
         c.value = hi[31:0];
      end else if (v < lo) begin
         c.sat = 1'b1;
         c.value = lo[31:0];
      end
      return c;
   endfunction

endpackage

// ===== src/vau_front.sv =====
// vau_front: input register, shared multipliers, subtract/scale/dot results
// and the sum of squares. Depends on vau_pkg.
module vau_front #(
   parameter int FRAC_BITS = 16,
   parameter int CW        = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  vau_pkg::req_type  in_data,
   output logic              out_valid,
   output vau_pkg::side_type out_side,
   output logic [63:0]       out_sumsq
);

   localparam logic signed [65:0] HALF = 66'sd1 <<< (FRAC_BITS - 1);

   logic               v1_ff;
   vau_pkg::req_type   q1_ff;
   logic signed [31:0] a_c [3];
   logic signed [31:0] b_c [3];
   logic signed [31:0] f_c;
   logic signed [31:0] op_c [3];
   vau_pkg::clamp_type sub_c [3];

   logic               v2_ff;
   vau_pkg::side_type  s2_ff;
   vau_pkg::side_type  s2_in;
   logic signed [63:0] p2_ff [3];
   logic signed [63:0] p2_in [3];

   vau_pkg::clamp_type scl_c [3];
   vau_pkg::clamp_type dot_c;
   logic               v3_ff;
   vau_pkg::side_type  s3_ff;
   vau_pkg::side_type  s3_in;
   logic [63:0]        sumsq_ff;
   logic [63:0]        sumsq_in;

   // stage 1 -> 2: operand select, multiply, subtract
   always_comb begin
      a_c[0] = 32'(signed'(q1_ff.a_x[CW-1:0]));
      a_c[1] = 32'(signed'(q1_ff.a_y[CW-1:0]));
      a_c[2] = 32'(signed'(q1_ff.a_z[CW-1:0]));
      b_c[0] = 32'(signed'(q1_ff.b_x[CW-1:0]));
      b_c[1] = 32'(signed'(q1_ff.b_y[CW-1:0]));
      b_c[2] = 32'(signed'(q1_ff.b_z[CW-1:0]));
      f_c    = 32'(signed'(q1_ff.factor[CW-1:0]));
      s2_in.cmd = q1_ff.command;
      s2_in.sc  = '0;
      for (int i = 0; i < 3; i++) begin
         if (q1_ff.command == vau_pkg::CMD_SCALE) begin
            op_c[i] = f_c;
         end else if (q1_ff.command == vau_pkg::CMD_DOT) begin
            op_c[i] = b_c[i];
         end else begin
            op_c[i] = a_c[i];
         end
         p2_in[i] = a_c[i] * op_c[i];
         sub_c[i] = vau_pkg::clamp_comp(66'(a_c[i]) - 66'(b_c[i]), CW);
         s2_in.a[i] = a_c[i];
         s2_in.r[i] = (q1_ff.command == vau_pkg::CMD_SUB) ? sub_c[i].value : 32'd0;
      end
      s2_in.sat = (q1_ff.command == vau_pkg::CMD_SUB) &&
                  (sub_c[0].sat || sub_c[1].sat || sub_c[2].sat);
   end

   // stage 2 -> 3: rounding, reduction, saturation
   always_comb begin
      s3_in = s2_ff;
      sumsq_in = 64'(p2_ff[0]) + 64'(p2_ff[1]) + 64'(p2_ff[2]);
      for (int i = 0; i < 3; i++) begin
         scl_c[i] = vau_pkg::clamp_comp((66'(p2_ff[i]) + HALF) >>> FRAC_BITS, CW);
      end
      dot_c = vau_pkg::clamp_comp(
         (66'(p2_ff[0]) + 66'(p2_ff[1]) + 66'(p2_ff[2]) + HALF) >>> FRAC_BITS, CW);
      case (s2_ff.cmd)
         vau_pkg::CMD_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               s3_in.r[i] = scl_c[i].value;
            end
            s3_in.sat = scl_c[0].sat || scl_c[1].sat || scl_c[2].sat;
         end
         vau_pkg::CMD_DOT: begin
            s3_in.sc  = dot_c.value;
            s3_in.sat = dot_c.sat;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         q1_ff    <= in_data;
         s2_ff    <= s2_in;
         p2_ff    <= p2_in;
         s3_ff    <= s3_in;
         sumsq_ff <= sumsq_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_side  = s3_ff;
   assign out_sumsq = sumsq_ff;

endmodule

// ===== src/vau_sqrt.sv =====
// vau_sqrt: pipelined integer square root, one root bit per stage.
// Depends on vau_pkg.
module vau_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  vau_pkg::side_type in_side,
   input  logic [63:0]       in_n,
   output logic              out_valid,
   output vau_pkg::side_type out_side,
   output logic [31:0]       out_root,
   output logic [33:0]       out_rem
);

   localparam int STEPS = 32;

   logic [STEPS-1:0]  vld_ff;
   logic [STEPS-1:0]  vld_p;
   vau_pkg::side_type side_ff [STEPS];
   vau_pkg::side_type side_p  [STEPS];
   logic [63:0]       n_ff    [STEPS];
   logic [63:0]       n_p     [STEPS];
   logic [31:0]       root_ff [STEPS];
   logic [31:0]       root_p  [STEPS];
   logic [31:0]       root_in [STEPS];
   logic [33:0]       rem_ff  [STEPS];
   logic [33:0]       rem_p   [STEPS];
   logic [33:0]       rem_in  [STEPS];
   logic [33:0]       work_c  [STEPS];
   logic [33:0]       trial_c [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      if (k == 0) begin : g_head
         assign vld_p[k]  = in_valid;
         assign side_p[k] = in_side;
         assign n_p[k]    = in_n;
         assign root_p[k] = '0;
         assign rem_p[k]  = '0;
      end else begin : g_body
         assign vld_p[k]  = vld_ff[k-1];
         assign side_p[k] = side_ff[k-1];
         assign n_p[k]    = n_ff[k-1];
         assign root_p[k] = root_ff[k-1];
         assign rem_p[k]  = rem_ff[k-1];
      end

      always_comb begin
         work_c[k]  = {rem_p[k][31:0], n_p[k][2*(STEPS-1-k)+1 -: 2]};
         trial_c[k] = {root_p[k], 2'b01};
         if (work_c[k] >= trial_c[k]) begin
            rem_in[k]  = work_c[k] - trial_c[k];
            root_in[k] = {root_p[k][30:0], 1'b1};
         end else begin
            rem_in[k]  = work_c[k];
            root_in[k] = {root_p[k][30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_p[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[k] <= side_p[k];
            n_ff[k]    <= n_p[k];
            root_ff[k] <= root_in[k];
            rem_ff[k]  <= rem_in[k];
         end
      end
   end

   assign out_valid = vld_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_rem   = rem_ff[STEPS-1];

endmodule

// ===== src/vau_div.sv =====
// vau_div: length rounding, pipelined restoring divide for the unit vector
// and the result register. Depends on vau_pkg.
module vau_div #(
   parameter int FRAC_BITS = 16,
   parameter int CW        = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  vau_pkg::side_type in_side,
   input  logic [31:0]       in_root,
   input  logic [33:0]       in_rem,
   output logic              out_valid,
   output vau_pkg::rsp_type  out_data
);

   localparam int QB = FRAC_BITS + 1;
   localparam int DW = FRAC_BITS + 33;

   logic [31:0]        len_c;
   vau_pkg::clamp_type len_cl_c;
   logic [31:0]        mag_c [3];
   vau_pkg::side_type  sp_in;
   logic [DW-1:0]      dp_in [3];

   logic               vp_ff;
   vau_pkg::side_type  sp_ff;
   logic [31:0]        lp_ff;
   logic               zp_ff;
   logic [DW-1:0]      dp_ff [3];

   logic [QB-1:0]     vld_ff;
   logic [QB-1:0]     vld_p;
   vau_pkg::side_type side_ff [QB];
   vau_pkg::side_type side_p  [QB];
   logic [31:0]       len_ff  [QB];
   logic [31:0]       len_p   [QB];
   logic [QB-1:0]     zero_ff;
   logic [QB-1:0]     zero_p;
   logic [DW-1:0]     d_ff    [QB][3];
   logic [DW-1:0]     d_p     [QB][3];
   logic [31:0]       rem_ff  [QB][3];
   logic [31:0]       rem_p   [QB][3];
   logic [31:0]       rem_in  [QB][3];
   logic [QB-1:0]     q_ff    [QB][3];
   logic [QB-1:0]     q_p     [QB][3];
   logic [QB-1:0]     q_in    [QB][3];
   logic [32:0]       work_c  [QB][3];

   logic signed [65:0] qs_c [3];
   vau_pkg::clamp_type unit_c [3];
   vau_pkg::side_type  sl_c;
   logic               unit_c_sel;
   logic               sat_c;
   vau_pkg::rsp_type   rsp_in;
   logic               rsp_valid_ff;
   vau_pkg::rsp_type   rsp_ff;

   // prep: round the root, length result, dividends
   always_comb begin
      len_c    = in_root + 32'(in_rem > {2'b00, in_root});
      len_cl_c = vau_pkg::clamp_comp(66'(len_c), CW);
      sp_in    = in_side;
      if (in_side.cmd == vau_pkg::CMD_LEN) begin
         sp_in.sc  = len_cl_c.value;
         sp_in.sat = len_cl_c.sat;
      end
      for (int i = 0; i < 3; i++) begin
         mag_c[i] = in_side.a[i][31] ? (~in_side.a[i] + 32'd1) : in_side.a[i];
         dp_in[i] = {1'b0, mag_c[i], {FRAC_BITS{1'b0}}} + DW'(len_c[31:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
      end else if (adv) begin
         vp_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sp_ff <= sp_in;
         lp_ff <= len_c;
         zp_ff <= (len_c == 32'd0);
         dp_ff <= dp_in;
      end
   end

   for (genvar j = 0; j < QB; j++) begin : g_step
      if (j == 0) begin : g_head
         assign vld_p[j]  = vp_ff;
         assign side_p[j] = sp_ff;
         assign len_p[j]  = lp_ff;
         assign zero_p[j] = zp_ff;
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign d_p[j][i]   = dp_ff[i];
            assign rem_p[j][i] = dp_ff[i][DW-1:QB];
            assign q_p[j][i]   = '0;
         end
      end else begin : g_body
         assign vld_p[j]  = vld_ff[j-1];
         assign side_p[j] = side_ff[j-1];
         assign len_p[j]  = len_ff[j-1];
         assign zero_p[j] = zero_ff[j-1];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign d_p[j][i]   = d_ff[j-1][i];
            assign rem_p[j][i] = rem_ff[j-1][i];
            assign q_p[j][i]   = q_ff[j-1][i];
         end
      end

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            work_c[j][i] = {rem_p[j][i], d_p[j][i][QB-1-j]};
            if (work_c[j][i] >= {1'b0, len_p[j]}) begin
               rem_in[j][i] = 32'(work_c[j][i] - {1'b0, len_p[j]});
               q_in[j][i]   = {q_p[j][i][QB-2:0], 1'b1};
            end else begin
               rem_in[j][i] = work_c[j][i][31:0];
               q_in[j][i]   = {q_p[j][i][QB-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv) begin
            vld_ff[j] <= vld_p[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            side_ff[j] <= side_p[j];
            len_ff[j]  <= len_p[j];
            zero_ff[j] <= zero_p[j];
            d_ff[j]    <= d_p[j];
            rem_ff[j]  <= rem_in[j];
            q_ff[j]    <= q_in[j];
         end
      end
   end

   // final: sign, saturate, status
   always_comb begin
      sl_c       = side_ff[QB-1];
      unit_c_sel = (sl_c.cmd == vau_pkg::CMD_UNIT);
      sat_c      = sl_c.sat;
      for (int i = 0; i < 3; i++) begin
         qs_c[i] = sl_c.a[i][31] ? -$signed(66'(q_ff[QB-1][i]))
                                 : $signed(66'(q_ff[QB-1][i]));
         unit_c[i] = vau_pkg::clamp_comp(qs_c[i], CW);
      end
      rsp_in.r_x = sl_c.r[0];
      rsp_in.r_y = sl_c.r[1];
      rsp_in.r_z = sl_c.r[2];
      rsp_in.scalar_result = sl_c.sc;
      if (unit_c_sel && !zero_ff[QB-1]) begin
         rsp_in.r_x = unit_c[0].value;
         rsp_in.r_y = unit_c[1].value;
         rsp_in.r_z = unit_c[2].value;
         sat_c = unit_c[0].sat || unit_c[1].sat || unit_c[2].sat;
      end
      if (unit_c_sel && zero_ff[QB-1]) begin
         rsp_in.status = vau_pkg::ST_ZERO;
      end else if (sat_c) begin
         rsp_in.status = vau_pkg::ST_SAT;
      end else begin
         rsp_in.status = vau_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vld_ff[QB-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

// ===== src/vector3_arithmetic_unit.sv =====
// Three-component Q-format vector unit: subtract, scale, dot, length and unit
// vector with saturation. A fully pipelined design: one transaction is taken
// every clock unless the pipeline is stalled. The pipeline holds the 32-stage
// square-root pipeline and the FRAC_BITS + 1 stage divider behind it; the
// input, multiplier and reduction stages add three more, and the
// length-rounding stage and the result register one each. A stall on the
// result side freezes the whole pipeline; empty stages are not squeezed out.
module vector3_arithmetic_unit #(
   parameter int FRAC_BITS  = 16,
   parameter int COMP_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  vau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output vau_pkg::rsp_type rsp_data
);

   localparam int CW = (COMP_WIDTH < 32) ? COMP_WIDTH : 32;

   logic              adv;
   logic              f_valid;
   vau_pkg::side_type f_side;
   logic [63:0]       f_sumsq;
   logic              s_valid;
   vau_pkg::side_type s_side;
   logic [31:0]       s_root;
   logic [33:0]       s_rem;

   assign req_stall = rsp_valid && rsp_stall;
   assign adv       = !req_stall;

   vau_front #(
      .FRAC_BITS(FRAC_BITS),
      .CW       (CW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (req_valid),
      .in_data  (req_data),
      .out_valid(f_valid),
      .out_side (f_side),
      .out_sumsq(f_sumsq)
   );

   vau_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (f_valid),
      .in_side  (f_side),
      .in_n     (f_sumsq),
      .out_valid(s_valid),
      .out_side (s_side),
      .out_root (s_root),
      .out_rem  (s_rem)
   );

   vau_div #(
      .FRAC_BITS(FRAC_BITS),
      .CW       (CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s_valid),
      .in_side  (s_side),
      .in_root  (s_root),
      .in_rem   (s_rem),
      .out_valid(rsp_valid),
      .out_data (rsp_data)
   );

   a_zero_len_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == vau_pkg::ST_ZERO |->
         rsp_data.r_x == 32'sd0 && rsp_data.r_y == 32'sd0 &&
         rsp_data.r_z == 32'sd0 && rsp_data.scalar_result == 32'sd0)
      else $error("zero-length transaction with nonzero fields");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3)
      else $error("undefined status code");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(f_valid) && $stable(s_valid) && $stable(f_side))
      else $error("pipeline moved during stall");

endmodule
